[rtl/arith_expression_tokenizer_core_defines.svh]
// Assertion macros used by the checker file of the tokenizer.
`ifndef ARITH_EXPRESSION_TOKENIZER_CORE_DEFINES_SVH
`define ARITH_EXPRESSION_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define AET_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define AET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/aet_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aet_pkg;

   // Number format
   localparam int INT_BITS    = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_DIGITS = 4;
   localparam int NUM_BITS    = INT_BITS + FRAC_BITS;

   // Elaboration-time power of ten
   function automatic longint pow10_const(input int n);
      longint p;
      p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   // Decimal fraction digits value, divisor and counters
   localparam int FVAL_BITS = $clog2(pow10_const(FRAC_DIGITS));
   localparam int DIV_BITS  = $clog2(pow10_const(FRAC_DIGITS) + 1);
   localparam int CNT_BITS  = $clog2(FRAC_DIGITS + 1);
   localparam int STEP_BITS = $clog2(FRAC_BITS + 1);
   localparam int FACC_BITS = FVAL_BITS + 4;
   localparam int IACC_BITS = INT_BITS + 4;

   // Byte queue between front and back (depth is a power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      KIND_NUMBER = 3'd0,
      KIND_OPERATOR = 3'd1,
      KIND_OPEN = 3'd2,
      KIND_CLOSE = 3'd3,
      KIND_ERROR = 3'd4,
      KIND_END = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_PLUS = 2'd0,
      OP_MINUS = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   // Byte classes produced by the front
   typedef enum logic [2:0] {
      CLS_DIGIT,
      CLS_DOT,
      CLS_SPACE,
      CLS_OP,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_END,
      CLS_BAD
   } cls_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_NUM,
      ST_TOK
   } state_type;

   // Queue entry: class plus digit value, operator code or raw byte
   typedef struct packed {
      cls_type    cls;
      logic [7:0] data;
   } entry_type;

   typedef struct packed {
      logic                 start;
      logic [FVAL_BITS-1:0] value;
      logic [CNT_BITS-1:0]  count;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [FRAC_BITS-1:0] quot;
   } div_res_type;

   // Run-time 10^n for n up to FRAC_DIGITS
   function automatic logic [DIV_BITS-1:0] pow10_sel(input logic [CNT_BITS-1:0] n);
      logic [DIV_BITS-1:0] p;
      p = DIV_BITS'(1);
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         if (CNT_BITS'(i) < n) p = p * DIV_BITS'(10);
      end
      return p;
   endfunction

endpackage

`default_nettype wire

[rtl/aet_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module aet_front (
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                q_full,
   output logic                in_stall,
   output logic                push,
   output aet_pkg::entry_type  push_entry
);
   import aet_pkg::*;

   // Accept whenever the queue has room
   assign in_stall = q_full;
   assign push     = in_valid && !q_full;

   // Byte classifier
   always_comb begin
      push_entry.cls  = CLS_BAD;
      push_entry.data = in_byte;
      unique case (in_byte) inside
         [CH_ZERO:CH_NINE]: begin
            push_entry.cls  = CLS_DIGIT;
            push_entry.data = {4'h0, in_byte[3:0]};
         end
         CH_DOT: push_entry.cls = CLS_DOT;
         CH_SPACE, CH_LF, CH_CR, CH_TAB: push_entry.cls = CLS_SPACE;
         CH_PLUS: begin
            push_entry.cls  = CLS_OP;
            push_entry.data = {6'h00, OP_PLUS};
         end
         CH_MINUS: begin
            push_entry.cls  = CLS_OP;
            push_entry.data = {6'h00, OP_MINUS};
         end
         CH_STAR: begin
            push_entry.cls  = CLS_OP;
            push_entry.data = {6'h00, OP_MUL};
         end
         CH_SLASH: begin
            push_entry.cls  = CLS_OP;
            push_entry.data = {6'h00, OP_DIV};
         end
         CH_LPAREN: push_entry.cls = CLS_OPEN;
         CH_RPAREN: push_entry.cls = CLS_CLOSE;
         CH_NUL: push_entry.cls = CLS_END;
         default: push_entry.cls = CLS_BAD;
      endcase
   end

endmodule

`default_nettype wire

[rtl/aet_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module aet_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  aet_pkg::entry_type  push_entry,
   input  logic                pop,
   output aet_pkg::entry_type  head,
   output logic                empty,
   output logic                full
);
   import aet_pkg::*;

   entry_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));

   // Pointer and fill level update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QUEUE_AW + 1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

[rtl/aet_frac_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: floor(value * 2^FRAC_BITS / 10^count), one quotient bit a cycle.
// value < 10^count, so the quotient fits FRAC_BITS.
module aet_frac_div (
   input  logic                  clock,
   input  logic                  reset,
   input  aet_pkg::div_req_type  req,
   output aet_pkg::div_res_type  res
);
   import aet_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_BITS-1:0]  steps_ff, steps_in;
   logic [DIV_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]   dvs_ff, dvs_in;
   logic [FRAC_BITS-1:0]  quot_ff, quot_in;

   logic [DIV_BITS:0]     trial;
   logic [DIV_BITS:0]     diff;
   logic                  ge;

   assign res.done = done_ff;
   assign res.quot = quot_ff;

   // One trial subtraction
   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, dvs_ff};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quot_in  = quot_ff;
      if (req.start) begin
         busy_in  = 1'b1;
         steps_in = STEP_BITS'(FRAC_BITS);
         rem_in   = DIV_BITS'(req.value);
         dvs_in   = pow10_sel(req.count);
         quot_in  = '0;
      end else if (busy_ff) begin
         rem_in   = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
         quot_in  = {quot_ff[FRAC_BITS-2:0], ge};
         steps_in = steps_ff - STEP_BITS'(1);
         if (steps_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff <= steps_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      quot_ff  <= quot_in;
   end

endmodule

`default_nettype wire

[rtl/aet_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module aet_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  aet_pkg::entry_type           q_head,
   output logic                         q_pop,
   output aet_pkg::div_req_type         div_req,
   input  aet_pkg::div_res_type         div_res,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_token_kind,
   output logic [1:0]                   rsp_operator_code,
   output logic [aet_pkg::NUM_BITS-1:0] rsp_number_value,
   output logic [7:0]                   rsp_offending_byte,
   output logic                         rsp_last_of_run
);
   import aet_pkg::*;

   // Bytes that give a token of their own
   function automatic logic has_tok(input entry_type e);
      return !(e.cls == CLS_DIGIT || e.cls == CLS_SPACE);
   endfunction

   state_type             state_ff, state_in;
   entry_type             cur_ff, cur_in;

   // Number under construction
   logic                  in_num_ff, in_num_in;
   logic                  seen_ff, seen_in;
   logic                  past2_ff, past2_in;
   logic [INT_BITS-1:0]   int_ff, int_in;
   logic [FVAL_BITS-1:0]  fval_ff, fval_in;
   logic [CNT_BITS-1:0]   fcnt_ff, fcnt_in;
   logic                  err_ff, err_in;

   // Output register
   logic                  rv_ff, rv_in;
   logic [2:0]            kind_ff, kind_in;
   logic [1:0]            op_ff, op_in;
   logic [NUM_BITS-1:0]   num_ff, num_in;
   logic [7:0]            bad_ff, bad_in;
   logic                  last_ff, last_in;

   logic                  out_free;
   logic                  hd_digit, hd_dot;
   logic                  drop, absorb, flush;
   logic                  take_tok, take_num, do_absorb, do_start;
   entry_type             tok_src;
   kind_type              tok_kind;
   logic [1:0]            tok_op;
   logic [7:0]            tok_bad;
   logic [IACC_BITS-1:0]  int_wide;
   logic [INT_BITS-1:0]   int_sat;
   logic [FACC_BITS-1:0]  fval_wide;

   assign out_free = !rv_ff || !rsp_stall;

   // Head byte decode
   assign hd_digit = (q_head.cls == CLS_DIGIT);
   assign hd_dot   = (q_head.cls == CLS_DOT);
   assign drop     = err_ff && (q_head.cls != CLS_END);
   assign absorb   = in_num_ff && (hd_digit || hd_dot);
   assign flush    = in_num_ff && !drop && !absorb;

   // Token from the head byte or from the byte held behind a flush
   assign tok_src = (state_ff == ST_IDLE) ? q_head : cur_ff;

   always_comb begin
      unique case (tok_src.cls)
         CLS_OP:    tok_kind = KIND_OPERATOR;
         CLS_OPEN:  tok_kind = KIND_OPEN;
         CLS_CLOSE: tok_kind = KIND_CLOSE;
         CLS_END:   tok_kind = KIND_END;
         default:   tok_kind = KIND_ERROR;
      endcase
      tok_op  = (tok_src.cls == CLS_OP) ? tok_src.data[1:0] : 2'b00;
      tok_bad = (tok_kind == KIND_ERROR) ? tok_src.data : 8'h00;
   end

   // Accumulators: integer saturates, fraction keeps its first digits
   assign int_wide  = IACC_BITS'(int_ff) * IACC_BITS'(10) + IACC_BITS'(q_head.data[3:0]);
   assign int_sat   = (|int_wide[IACC_BITS-1:INT_BITS]) ? '1 : int_wide[INT_BITS-1:0];
   assign fval_wide = FACC_BITS'(fval_ff) * FACC_BITS'(10) + FACC_BITS'(q_head.data[3:0]);

   // FSM outputs
   always_comb begin
      q_pop         = 1'b0;
      div_req.start = 1'b0;
      take_tok      = 1'b0;
      take_num      = 1'b0;
      do_absorb     = 1'b0;
      do_start      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (drop) begin
                  q_pop = 1'b1;
               end else if (absorb) begin
                  q_pop     = 1'b1;
                  do_absorb = 1'b1;
               end else if (flush) begin
                  q_pop         = 1'b1;
                  div_req.start = 1'b1;
               end else if (has_tok(q_head)) begin
                  q_pop    = out_free;
                  take_tok = out_free;
               end else begin
                  q_pop    = 1'b1;
                  do_start = hd_digit;
               end
            end
         end
         ST_DIV: ;
         ST_NUM: take_num = out_free;
         ST_TOK: take_tok = out_free;
         default: ;
      endcase
   end

   assign div_req.value = fval_ff;
   assign div_req.count = fcnt_ff;

   // FSM next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty && flush) state_in = ST_DIV;
         ST_DIV:  if (div_res.done) state_in = ST_NUM;
         ST_NUM: begin
            if (out_free) state_in = has_tok(cur_ff) ? ST_TOK : ST_IDLE;
         end
         ST_TOK:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign cur_in = div_req.start ? q_head : cur_ff;

   // Number and error state
   always_comb begin
      in_num_in = in_num_ff;
      seen_in   = seen_ff;
      past2_in  = past2_ff;
      int_in    = int_ff;
      fval_in   = fval_ff;
      fcnt_in   = fcnt_ff;
      err_in    = err_ff;
      if (do_absorb && !past2_ff) begin
         if (hd_dot) begin
            if (seen_ff) past2_in = 1'b1;
            else seen_in = 1'b1;
         end else if (seen_ff) begin
            if (fcnt_ff < CNT_BITS'(FRAC_DIGITS)) begin
               fval_in = fval_wide[FVAL_BITS-1:0];
               fcnt_in = fcnt_ff + CNT_BITS'(1);
            end
         end else begin
            int_in = int_sat;
         end
      end
      if (do_start) begin
         in_num_in = 1'b1;
         seen_in   = 1'b0;
         past2_in  = 1'b0;
         int_in    = INT_BITS'(q_head.data[3:0]);
         fval_in   = '0;
         fcnt_in   = '0;
      end
      // Number emitted, or end of text: back to an empty number
      if (take_num || (take_tok && tok_kind == KIND_END)) begin
         in_num_in = 1'b0;
         seen_in   = 1'b0;
         past2_in  = 1'b0;
         int_in    = '0;
         fval_in   = '0;
         fcnt_in   = '0;
      end
      if (take_tok && tok_kind == KIND_ERROR) err_in = 1'b1;
      if (take_tok && tok_kind == KIND_END) err_in = 1'b0;
   end

   // Output register load
   always_comb begin
      rv_in   = rv_ff && rsp_stall;
      kind_in = kind_ff;
      op_in   = op_ff;
      num_in  = num_ff;
      bad_in  = bad_ff;
      last_in = last_ff;
      if (take_num) begin
         rv_in   = 1'b1;
         kind_in = KIND_NUMBER;
         op_in   = 2'b00;
         num_in  = {int_ff, div_res.quot};
         bad_in  = 8'h00;
         last_in = !has_tok(cur_ff);
      end else if (take_tok) begin
         rv_in   = 1'b1;
         kind_in = tok_kind;
         op_in   = tok_op;
         num_in  = '0;
         bad_in  = tok_bad;
         last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         in_num_ff <= 1'b0;
         seen_ff   <= 1'b0;
         past2_ff  <= 1'b0;
         int_ff    <= '0;
         fval_ff   <= '0;
         fcnt_ff   <= '0;
         err_ff    <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_num_ff <= in_num_in;
         seen_ff   <= seen_in;
         past2_ff  <= past2_in;
         int_ff    <= int_in;
         fval_ff   <= fval_in;
         fcnt_ff   <= fcnt_in;
         err_ff    <= err_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      kind_ff <= kind_in;
      op_ff   <= op_in;
      num_ff  <= num_in;
      bad_ff  <= bad_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_token_kind     = kind_ff;
   assign rsp_operator_code  = op_ff;
   assign rsp_number_value   = num_ff;
   assign rsp_offending_byte = bad_ff;
   assign rsp_last_of_run    = last_ff;

endmodule

`default_nettype wire

[rtl/arith_expression_tokenizer_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Path: a token beat is registered in the byte queue and then in the output register; a number
//   beat waits for the fraction divider after the byte that ends the number leaves the queue.
// Throughput: 1 byte a cycle for digits, dots, spaces and single tokens while the output is not
//   stalled; ending a number holds further bytes in the queue during the bit-serial fraction divider.
// Reset: synchronous, active high; the byte queue, number state and output beat are cleared.
module arith_expression_tokenizer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_text_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_token_kind,
   output logic [1:0]                   rsp_operator_code,
   output logic [aet_pkg::NUM_BITS-1:0] rsp_number_value,
   output logic [7:0]                   rsp_offending_byte,
   output logic                         rsp_last_of_run
);
   import aet_pkg::*;

   logic         push, pop, q_empty, q_full;
   entry_type    push_entry, q_head;
   div_req_type  div_req;
   div_res_type  div_res;

   // Byte classifier
   aet_front u_front (
      .in_valid   (req_valid),
      .in_byte    (req_text_byte),
      .q_full     (q_full),
      .in_stall   (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   // Classified bytes waiting for the back end
   aet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Fraction scaling for number tokens
   aet_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .res   (div_res)
   );

   // Token sequencer and output register
   aet_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_head             (q_head),
      .q_pop              (pop),
      .div_req            (div_req),
      .div_res            (div_res),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_operator_code  (rsp_operator_code),
      .rsp_number_value   (rsp_number_value),
      .rsp_offending_byte (rsp_offending_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

`default_nettype wire

[rtl/aet_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "arith_expression_tokenizer_core_defines.svh"

module aet_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [7:0]                   req_text_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [2:0]                   rsp_token_kind,
   input logic [1:0]                   rsp_operator_code,
   input logic [aet_pkg::NUM_BITS-1:0] rsp_number_value,
   input logic [7:0]                   rsp_offending_byte,
   input logic                         rsp_last_of_run
);
   import aet_pkg::*;

   // Stalled beat holds
   `AET_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_number_value) && $stable(rsp_last_of_run), "stalled beat changed")

   // Only defined token kinds
   `AET_ASSERT_SAME(a_kind_range, clock, reset, rsp_valid, rsp_token_kind <= KIND_END, "bad token kind")

   // Value only on number beats
   `AET_ASSERT_SAME(a_num_zero, clock, reset, rsp_valid && rsp_token_kind != KIND_NUMBER, rsp_number_value == '0, "value on non-number beat")

   // Offending byte only on error beats
   `AET_ASSERT_SAME(a_bad_zero, clock, reset, rsp_valid && rsp_token_kind != KIND_ERROR, rsp_offending_byte == 8'h00, "byte on non-error beat")

   // End token closes its run
   `AET_ASSERT_SAME(a_end_last, clock, reset, rsp_valid && rsp_token_kind == KIND_END, rsp_last_of_run, "end beat not last")

endmodule

bind arith_expression_tokenizer_core aet_checker u_aet_checker (.*);

`default_nettype wire

[tb/tb_arith_expression_tokenizer_core.sv]
`timescale 1ns / 1ps

module tb_arith_expression_tokenizer_core;
   import aet_pkg::*;

   localparam int CLK_PERIOD  = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int END_WAIT    = 40;
   localparam int PRINT_LIMIT = 100;

   // One token as the lexer should emit it
   typedef struct {
      kind_type            kind;
      op_type              op;
      logic [NUM_BITS-1:0] value;
      logic [7:0]          bad_byte;
      logic                last;
   } token_rec;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic [7:0]          req_text_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [2:0]          rsp_token_kind;
   logic [1:0]          rsp_operator_code;
   logic [NUM_BITS-1:0] rsp_number_value;
   logic [7:0]          rsp_offending_byte;
   logic                rsp_last_of_run;

   token_rec expected_tokens[$];
   int       error_count   = 0;
   int       cycle_count   = 0;
   int       lexed_bytes   = 0;
   int       burst_left    = 0;
   int       hold_request  = 0;

   // Lexer state mirror
   logic                num_active        = 1'b0;
   logic                point_seen        = 1'b0;
   logic                second_point_seen = 1'b0;
   logic [INT_BITS-1:0] int_value         = '0;
   int unsigned         frac_value        = 0;
   int unsigned         frac_count        = 0;
   logic                error_blocked     = 1'b0;

   arith_expression_tokenizer_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_text_byte      (req_text_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_token_kind     (rsp_token_kind),
      .rsp_operator_code  (rsp_operator_code),
      .rsp_number_value   (rsp_number_value),
      .rsp_offending_byte (rsp_offending_byte),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_arith_expression_tokenizer_core: done, errors");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[cycle %0d] %s", cycle_count, msg);
   endtask

   // ---------------------------------------------------------------
   // Token prediction
   // ---------------------------------------------------------------
   function automatic logic [NUM_BITS-1:0] fixed_point_value();
      longint unsigned divisor;
      longint unsigned frac;
      divisor = 1;
      for (int i = 0; i < int'(frac_count); i++) divisor = divisor * 10;
      frac = (64'(frac_value) << FRAC_BITS) / divisor;
      return (NUM_BITS'(int_value) << FRAC_BITS) | NUM_BITS'(frac);
   endfunction

   task automatic push_token(input kind_type kind, input op_type op,
                             input logic [NUM_BITS-1:0] value, input logic [7:0] bad_byte);
      token_rec t;
      t.kind     = kind;
      t.op       = op;
      t.value    = value;
      t.bad_byte = bad_byte;
      t.last     = 1'b0;
      expected_tokens.push_back(t);
   endtask

   task automatic clear_number();
      num_active        = 1'b0;
      point_seen        = 1'b0;
      second_point_seen = 1'b0;
      int_value         = '0;
      frac_value        = 0;
      frac_count        = 0;
   endtask

   task automatic flush_number();
      if (num_active) begin
         push_token(KIND_NUMBER, OP_PLUS, fixed_point_value(), 8'h00);
         clear_number();
      end
   endtask

   task automatic predict_tokens(input logic [7:0] ch);
      int              run_start;
      logic            is_digit;
      logic [63:0]     wide;
      logic [63:0]     int_max;
      run_start = expected_tokens.size();
      is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
      int_max   = (64'd1 << INT_BITS) - 64'd1;
      if (ch == CH_NUL) begin
         // terminator: flush unless blocked, then end token and full clear
         if (!error_blocked) flush_number();
         push_token(KIND_END, OP_PLUS, '0, 8'h00);
         clear_number();
         error_blocked = 1'b0;
      end else if (!error_blocked) begin
         if (num_active && (is_digit || ch == CH_DOT)) begin
            // extend the number; everything after a second dot is dropped
            if (!second_point_seen) begin
               if (ch == CH_DOT) begin
                  if (point_seen) second_point_seen = 1'b1;
                  else point_seen = 1'b1;
               end else if (point_seen) begin
                  if (frac_count < FRAC_DIGITS) begin
                     frac_value = frac_value * 10 + 32'(ch - CH_ZERO);
                     frac_count++;
                  end
               end else begin
                  wide = 64'(int_value) * 64'd10 + 64'(ch - CH_ZERO);
                  int_value = (wide > int_max) ? '1 : wide[INT_BITS-1:0];
               end
            end
         end else begin
            flush_number();
            if (is_digit) begin
               num_active = 1'b1;
               int_value  = INT_BITS'(ch - CH_ZERO);
            end else begin
               case (ch)
                  CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
                  CH_PLUS:   push_token(KIND_OPERATOR, OP_PLUS, '0, 8'h00);
                  CH_MINUS:  push_token(KIND_OPERATOR, OP_MINUS, '0, 8'h00);
                  CH_STAR:   push_token(KIND_OPERATOR, OP_MUL, '0, 8'h00);
                  CH_SLASH:  push_token(KIND_OPERATOR, OP_DIV, '0, 8'h00);
                  CH_LPAREN: push_token(KIND_OPEN, OP_PLUS, '0, 8'h00);
                  CH_RPAREN: push_token(KIND_CLOSE, OP_PLUS, '0, 8'h00);
                  default: begin
                     push_token(KIND_ERROR, OP_PLUS, '0, ch);
                     error_blocked = 1'b1;
                  end
               endcase
            end
         end
      end
      if (expected_tokens.size() > run_start)
         expected_tokens[expected_tokens.size() - 1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------
   // Bursts of random length, random gaps in between; gap 0 keeps valid up
   task automatic send_byte(input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_text_byte <= ch;
      do @(posedge clock); while (req_stall);
      if (!error_blocked || ch == CH_NUL) lexed_bytes++;
      predict_tokens(ch);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Stop offering and let every predicted token come out
   task automatic wait_tokens_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_operator();
      case ($urandom_range(0, 3))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(0, 5))
         0:       return CH_TAB;
         1:       return CH_LF;
         2:       return CH_CR;
         default: return CH_SPACE;
      endcase
   endfunction

   // Mostly short integers; now and then long ones that saturate,
   // fractions past the counted digits and junk after a second dot
   task automatic send_number();
      int n_int;
      n_int = ($urandom_range(0, 12) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
      if ($urandom_range(0, 15) == 0) begin
         repeat (n_int) send_byte(CH_NINE);
      end else begin
         repeat (n_int) send_byte(rand_digit());
      end
      if ($urandom_range(0, 1) == 1) begin
         send_byte(CH_DOT);
         repeat ($urandom_range(0, 6)) send_byte(rand_digit());
         if ($urandom_range(0, 7) == 0) begin
            send_byte(CH_DOT);
            repeat ($urandom_range(0, 4))
               send_byte(($urandom_range(0, 2) == 0) ? CH_DOT : rand_digit());
         end
      end
   endtask

   // One expression: terms with optional parens, joined by operators,
   // loose whitespace, optional junk bytes, then the terminator
   task automatic send_expression(input int noise_pct);
      int n_terms;
      n_terms = $urandom_range(1, 6);
      for (int t = 0; t < n_terms; t++) begin
         if ($urandom_range(0, 4) == 0) send_byte(CH_LPAREN);
         send_number();
         if ($urandom_range(0, 2) == 0) send_byte(rand_space());
         if ($urandom_range(0, 4) == 0) send_byte(CH_RPAREN);
         if ($urandom_range(0, 99) < noise_pct) send_byte(8'($urandom_range(0, 255)));
         if (t < n_terms - 1) begin
            send_byte(rand_operator());
            if ($urandom_range(0, 3) == 0) send_byte(rand_space());
         end
      end
      send_byte(CH_NUL);
   endtask

   // ---------------------------------------------------------------
   // Receiver: stall pattern with its own modes, plus requested hold-offs
   // ---------------------------------------------------------------
   initial begin : stall_pattern
      int pct;
      int mode_left;
      int hold_left;
      pct       = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(16, 200);
            case ($urandom_range(0, 3))
               0:       pct = 0;
               1:       pct = 20;
               2:       pct = 50;
               default: pct = 85;
            endcase
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   // Compare every accepted beat with the oldest predicted token
   always @(posedge clock) begin
      token_rec want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            report_error($sformatf("unexpected beat kind=%0d", rsp_token_kind));
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_kind !== want.kind)
               report_error($sformatf("token_kind got %0d want %0d",
                                      rsp_token_kind, want.kind));
            if (rsp_operator_code !== want.op)
               report_error($sformatf("operator_code got %0d want %0d",
                                      rsp_operator_code, want.op));
            if (rsp_number_value !== want.value)
               report_error($sformatf("number_value got %h want %h",
                                      rsp_number_value, want.value));
            if (rsp_offending_byte !== want.bad_byte)
               report_error($sformatf("offending_byte got %h want %h",
                                      rsp_offending_byte, want.bad_byte));
            if (rsp_last_of_run !== want.last)
               report_error($sformatf("last_of_run got %b want %b",
                                      rsp_last_of_run, want.last));
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // All operators and parens, a zero-led number, surplus fraction digits,
   // a second dot with trailing digit, whitespace end, then a lone ')'
   task automatic test_tokens_and_fraction();
      send_text("(+-*/0.12345.7 )");
      wait_tokens_drained();
   endtask

   // Integer part past 32 bits saturates; terminator flushes the number
   task automatic test_saturation();
      send_text("9999999999");
      send_byte(CH_NUL);
      wait_tokens_drained();
   endtask

   // Unknown byte flushes the number and blocks until the terminator;
   // a dot with no number in front is unknown
   task automatic test_error_hold();
      send_byte(8'h33);
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_byte(CH_DOT);
      send_byte(CH_NUL);
      wait_tokens_drained();
   endtask

   task automatic test_random_text();
      int target;
      target = lexed_bytes + 800;
      while (lexed_bytes < target) send_expression(0);
      wait_tokens_drained();
   endtask

   // Receiver holds off for long stretches while bytes keep coming
   task automatic test_stall_fill();
      int target;
      target = lexed_bytes + 200;
      while (lexed_bytes < target) begin
         hold_request = $urandom_range(150, 400);
         send_expression(0);
         send_expression(0);
      end
      wait_tokens_drained();
   endtask

   task automatic test_noise();
      int target;
      target = lexed_bytes + 350;
      while (lexed_bytes < target) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NUL);
         end else begin
            send_expression(15);
         end
      end
      wait_tokens_drained();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_tokens_and_fraction();
      test_saturation();
      test_error_hold();
      test_random_text();
      test_stall_fill();
      test_noise();
      // catch any stray beats after the last token
      repeat (END_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_arith_expression_tokenizer_core: done, clean");
      end else begin
         $display("tb_arith_expression_tokenizer_core: done, errors");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/aet_pkg.sv
rtl/aet_front.sv
rtl/aet_queue.sv
rtl/aet_frac_div.sv
rtl/aet_back.sv
rtl/arith_expression_tokenizer_core.sv
rtl/aet_checker.sv
tb/tb_arith_expression_tokenizer_core.sv
